[rtl/tfn_pkg.sv]
// Shared constants for the triangle face normal block.
package tfn_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int NORMAL_FRAC_DEF = 30;
	localparam int NORMAL_WIDTH    = 32;
endpackage

[rtl/triangle_face_normal.sv]
// Triangle unit normal: exact cross product, then a pipelined bit-by-bit normalization.
//
// Takes one triangle (three vertices, signed fixed point) per clock and returns the unit
// normal of edge1 x edge2 in signed Q2.NORMAL_FRAC_BITS, each component truncated toward
// zero, along with a degenerate flag (zero-length cross product, normal forced to zero).
// The block accepts a new item every cycle while the output is not stalled; a stall at the
// output holds the whole pipeline. Seven stages compute the edges, the cross products, their
// squares and the squared length; then come one stage per result bit of the normalization
// and one output register.
// The normalization stages carry the remainder and the running product of the squared
// length with the partial result, so each stage needs only one wide compare and subtract.
module triangle_face_normal
	import tfn_pkg::*;
#(
	parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           vtx_valid,
	output logic                           vtx_stall,
	input  logic signed [COORD_WIDTH-1:0]  first_x,
	input  logic signed [COORD_WIDTH-1:0]  first_y,
	input  logic signed [COORD_WIDTH-1:0]  first_z,
	input  logic signed [COORD_WIDTH-1:0]  second_x,
	input  logic signed [COORD_WIDTH-1:0]  second_y,
	input  logic signed [COORD_WIDTH-1:0]  second_z,
	input  logic signed [COORD_WIDTH-1:0]  third_x,
	input  logic signed [COORD_WIDTH-1:0]  third_y,
	input  logic signed [COORD_WIDTH-1:0]  third_z,
	output logic                           nrm_valid,
	input  logic                           nrm_stall,
	output logic signed [NORMAL_WIDTH-1:0] normal_x,
	output logic signed [NORMAL_WIDTH-1:0] normal_y,
	output logic signed [NORMAL_WIDTH-1:0] normal_z,
	output logic                           degenerate
);

	localparam int E  = COORD_WIDTH + 1;
	localparam int SW = 4 * E;
	localparam int NF = NORMAL_FRAC_BITS;
	localparam int MW = NF + 1;
	localparam int UW = SW + NF + 2;
	localparam int RW = SW + NF + 5;

	logic adv;
	assign adv       = !nrm_valid || !nrm_stall;
	assign vtx_stall = !adv;

	logic signed [COORD_WIDTH-1:0] p1 [3];
	logic signed [COORD_WIDTH-1:0] p2 [3];
	logic signed [COORD_WIDTH-1:0] p3 [3];
	assign p1[0] = first_x;
	assign p1[1] = first_y;
	assign p1[2] = first_z;
	assign p2[0] = second_x;
	assign p2[1] = second_y;
	assign p2[2] = second_z;
	assign p3[0] = third_x;
	assign p3[1] = third_y;
	assign p3[2] = third_z;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [E-1:0]   e1_s1  [3];
	logic signed [E-1:0]   e2_s1  [3];
	logic signed [2*E-1:0] pa_s2  [3];
	logic signed [2*E-1:0] pb_s2  [3];
	logic signed [2*E:0]   c_s3   [3];
	logic [2*E-1:0]        mag_s4 [3];
	logic                  neg_s4 [3];
	logic [2*E-1:0]        hh_s5  [3];
	logic [2*E-1:0]        hl_s5  [3];
	logic [2*E-1:0]        ll_s5  [3];
	logic                  neg_s5 [3];
	logic                  deg_s5;
	logic [SW-1:0]         sq_s6  [3];
	logic                  neg_s6 [3];
	logic                  deg_s6;

	// Normalization stages: index 0 is the seventh stage, index k the k-th bit stage.
	logic                  v_sk   [NF+2];
	logic                  deg_sk [NF+2];
	logic                  neg_sk [NF+2][3];
	logic [MW-1:0]         m_sk   [NF+2][3];
	logic [RW-1:0]         r_sk   [NF+1][3];
	logic [UW-1:0]         u_sk   [NF+1][3];
	logic [SW-1:0]         s_sk   [NF+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vtx_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= E'(p2[i]) - E'(p1[i]);
				e2_s1[i] <= E'(p3[i]) - E'(p1[i]);
				c_s3[i]  <= (2*E+1)'(pa_s2[i]) - (2*E+1)'(pb_s2[i]);
				neg_s4[i] <= c_s3[i][2*E];
				mag_s4[i] <= c_s3[i][2*E] ? (2*E)'(-c_s3[i]) : (2*E)'(c_s3[i]);
				hh_s5[i]  <= (2*E)'(mag_s4[i][2*E-1:E] * mag_s4[i][2*E-1:E]);
				hl_s5[i]  <= (2*E)'(mag_s4[i][2*E-1:E] * mag_s4[i][E-1:0]);
				ll_s5[i]  <= (2*E)'(mag_s4[i][E-1:0] * mag_s4[i][E-1:0]);
				neg_s5[i] <= neg_s4[i];
				sq_s6[i]  <= (SW'(hh_s5[i]) << (2*E)) + (SW'(hl_s5[i]) << (E+1))
					+ SW'(ll_s5[i]);
				neg_s6[i] <= neg_s5[i];
				// The squared component seeds the remainder of the bit recurrence.
				r_sk[0][i]   <= RW'(sq_s6[i]);
				u_sk[0][i]   <= '0;
				m_sk[0][i]   <= '0;
				neg_sk[0][i] <= neg_s6[i];
			end
			deg_s5    <= (mag_s4[0] == '0) && (mag_s4[1] == '0) && (mag_s4[2] == '0);
			deg_s6    <= deg_s5;
			s_sk[0]   <= sq_s6[0] + sq_s6[1] + sq_s6[2];
			deg_sk[0] <= deg_s6;
		end
	end

	generate
		for (genvar i = 0; i < 3; i++) begin : g_cross
			localparam int A = (i + 1) % 3;
			localparam int B = (i + 2) % 3;
			always_ff @(posedge clk) begin
				if (adv) begin
					pa_s2[i] <= e1_s1[A] * e2_s1[B];
					pb_s2[i] <= e2_s1[A] * e1_s1[B];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk[0] <= 1'b0;
		end else if (adv) begin
			v_sk[0] <= v_s6;
		end
	end

	// One result bit per stage, most significant first. With U = S * m so far, the next
	// bit is set when the remainder covers 4U + S; the remainder is then scaled by four.
	generate
		for (genvar j = 0; j <= NF; j++) begin : g_bit
			logic [RW-1:0] dv [3];
			logic          ge [3];

			always_comb begin
				for (int i = 0; i < 3; i++) begin
					dv[i] = (RW'(u_sk[j][i]) << 2) + RW'(s_sk[j]);
					ge[i] = r_sk[j][i] >= dv[i];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sk[j+1] <= 1'b0;
				end else if (adv) begin
					v_sk[j+1] <= v_sk[j];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					for (int i = 0; i < 3; i++) begin
						m_sk[j+1][i]   <= {m_sk[j][i][MW-2:0], ge[i]};
						neg_sk[j+1][i] <= neg_sk[j][i];
					end
					deg_sk[j+1] <= deg_sk[j];
				end
			end

			if (j < NF) begin : g_carry
				always_ff @(posedge clk) begin
					if (adv) begin
						for (int i = 0; i < 3; i++) begin
							r_sk[j+1][i] <= ge[i] ? ((r_sk[j][i] - dv[i]) << 2)
								: (r_sk[j][i] << 2);
							u_sk[j+1][i] <= ge[i] ? ((u_sk[j][i] << 1) + UW'(s_sk[j]))
								: (u_sk[j][i] << 1);
						end
						s_sk[j+1] <= s_sk[j];
					end
				end
			end
		end
	endgenerate

	logic signed [NORMAL_WIDTH-1:0] res [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (deg_sk[NF+1]) begin
				res[i] = '0;
			end else if (neg_sk[NF+1][i]) begin
				res[i] = -NORMAL_WIDTH'(m_sk[NF+1][i]);
			end else begin
				res[i] = NORMAL_WIDTH'(m_sk[NF+1][i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_valid <= 1'b0;
		end else if (adv) begin
			nrm_valid <= v_sk[NF+1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			normal_x   <= res[0];
			normal_y   <= res[1];
			normal_z   <= res[2];
			degenerate <= deg_sk[NF+1];
		end
	end

	localparam logic signed [NORMAL_WIDTH-1:0] UNIT = NORMAL_WIDTH'(1) << NF;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate item carries a nonzero normal");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_valid && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
		else $error("valid triangle gave a zero normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_valid |-> normal_x <= UNIT && normal_x >= -UNIT && normal_y <= UNIT
			&& normal_y >= -UNIT && normal_z <= UNIT && normal_z >= -UNIT)
		else $error("normal component beyond unit length");

endmodule

[verif/triangle_face_normal_tb.sv]
// Testbench for triangle_face_normal: exact cross-product normal predictor with random idling.
`timescale 1ns / 1ps

module triangle_face_normal_tb;
	import tfn_pkg::*;

	typedef struct {
		logic signed [31:0] v[9];
	} tri_t;

	typedef struct {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic               deg;
	} normal_t;

	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;
	logic vtx_valid;
	logic vtx_stall;
	logic signed [31:0] coord[9];
	logic nrm_valid;
	logic nrm_stall;
	logic signed [31:0] normal_x, normal_y, normal_z;
	logic degenerate;

	normal_t expected_normals[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit item_taken;

	always #5 clk = ~clk;

	triangle_face_normal dut (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
		.first_x(coord[0]), .first_y(coord[1]), .first_z(coord[2]),
		.second_x(coord[3]), .second_y(coord[4]), .second_z(coord[5]),
		.third_x(coord[6]), .third_y(coord[7]), .third_z(coord[8]),
		.nrm_valid(nrm_valid), .nrm_stall(nrm_stall),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);

	// Largest m in [0, 2^30] with m*m*len2 <= c*c*4^30, signed like c.
	function automatic logic signed [31:0] unit_component(logic signed [67:0] c,
			logic [199:0] len2);
		logic [199:0] cm, target, m, cand;
		cm = '0;
		cm[67:0] = c[67] ? -c : c;
		target = (cm * cm) << (2 * NORMAL_FRAC_DEF);
		m = '0;
		for (int b = NORMAL_FRAC_DEF; b >= 0; b--) begin
			cand = m | (200'd1 << b);
			if (cand * cand * len2 <= target)
				m = cand;
		end
		return c[67] ? -m[31:0] : m[31:0];
	endfunction

	function automatic normal_t face_normal(tri_t t);
		logic signed [67:0] e1[3], e2[3];
		logic signed [67:0] cx, cy, cz;
		logic [199:0] mx, my, mz, len2;
		normal_t r;
		for (int i = 0; i < 3; i++) begin
			e1[i] = 68'(t.v[3 + i]) - 68'(t.v[i]);
			e2[i] = 68'(t.v[6 + i]) - 68'(t.v[i]);
		end
		cx = e1[1] * e2[2] - e2[1] * e1[2];
		cy = e1[2] * e2[0] - e2[2] * e1[0];
		cz = e1[0] * e2[1] - e2[0] * e1[1];
		mx = '0; my = '0; mz = '0;
		mx[67:0] = cx[67] ? -cx : cx;
		my[67:0] = cy[67] ? -cy : cy;
		mz[67:0] = cz[67] ? -cz : cz;
		len2 = mx * mx + my * my + mz * mz;
		if (len2 == 0) begin
			r.nx = 0; r.ny = 0; r.nz = 0; r.deg = 1'b1;
		end else begin
			r.nx = unit_component(cx, len2);
			r.ny = unit_component(cy, len2);
			r.nz = unit_component(cz, len2);
			r.deg = 1'b0;
		end
		return r;
	endfunction

	task automatic send_triangle(tri_t t);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_valid <= 1'b1;
		for (int i = 0; i < 9; i++)
			coord[i] <= t.v[i];
		@(posedge clk);
		while (vtx_stall)
			@(posedge clk);
		expected_normals.insert(expected_normals.size(), face_normal(t));
	endtask

	function automatic tri_t rand_triangle(int kind);
		tri_t t;
		int sh;
		sh = $urandom_range(0, 31);
		for (int i = 0; i < 9; i++) begin
			case (kind)
				0: t.v[i] = $urandom;
				1: t.v[i] = $signed($urandom) >>> sh;
				default: t.v[i] = $signed($urandom) >>> 20;
			endcase
		end
		// Degenerate shapes: repeated vertex or third vertex on the first edge line.
		if (kind == 2) begin
			case ($urandom_range(0, 2))
				0: for (int i = 0; i < 3; i++) t.v[6 + i] = t.v[i];
				1: for (int i = 0; i < 3; i++) t.v[3 + i] = t.v[i];
				default: for (int i = 0; i < 3; i++)
					t.v[6 + i] = t.v[i] + 3 * (t.v[3 + i] - t.v[i]);
			endcase
		end
		return t;
	endfunction

	task automatic test_directed();
		logic signed [31:0] mn, mx;
		tri_t t;
		mn = 32'sh8000_0000;
		mx = 32'sh7fff_ffff;
		t.v = '{default: 0};
		send_triangle(t);
		t.v = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0};
		send_triangle(t);
		t.v = '{0, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
		send_triangle(t);
		t.v = '{0, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
		send_triangle(t);
		t.v = '{0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0, 0};
		send_triangle(t);
		t.v = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
		send_triangle(t);
		t.v = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
		send_triangle(t);
		t.v = '{mn, mn, mn, mx, mx, mx, mn, mx, mx};
		send_triangle(t);
		t.v = '{mx, mn, mx, mn, mx, mn, mn, mn, mx};
		send_triangle(t);
		t.v = '{mn, mn, mn, mx, mx, mx, mn, mn, mn};
		send_triangle(t);
		t.v = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
		send_triangle(t);
		t.v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		send_triangle(t);
		t.v = '{-1, -1, -1, 1, 1, 1, 1, -1, 0};
		send_triangle(t);
		t.v = '{0, 0, 0, 1, 1, 0, 1, 0, 1};
		send_triangle(t);
		t.v = '{mn, 0, mx, 0, mx, mn, mx, mn, 0};
		send_triangle(t);
	endtask

	task automatic test_random_full(int n);
		for (int i = 0; i < n; i++)
			send_triangle(rand_triangle(0));
	endtask

	task automatic test_random_scaled(int n);
		for (int i = 0; i < n; i++)
			send_triangle(rand_triangle(1));
	endtask

	task automatic test_degenerate(int n);
		for (int i = 0; i < n; i++)
			send_triangle(rand_triangle(2));
	endtask

	task automatic test_back_to_back(int n);
		quiet = 1'b1;
		for (int i = 0; i < n; i++)
			send_triangle(rand_triangle($urandom_range(0, 2)));
	endtask

	// Output side: random stall bursts, checking, and the watchdog.
	int stall_left = 0;
	int free_left = 0;
	always @(posedge clk or negedge arst_n) begin
		normal_t e;
		if (!arst_n) begin
			nrm_stall <= 1'b0;
			stall_left = 0;
			free_left = 0;
		end else begin
			item_taken = vtx_valid && !vtx_stall;
			if (nrm_valid && !nrm_stall) begin
				item_taken = 1'b1;
				if (expected_normals.size() == 0) begin
					$error("normal result with no pending triangle");
					errors++;
				end else begin
					e = expected_normals.pop_front();
					if (normal_x !== e.nx) begin
						$error("normal_x expected %0d actual %0d", e.nx, normal_x);
						errors++;
					end
					if (normal_y !== e.ny) begin
						$error("normal_y expected %0d actual %0d", e.ny, normal_y);
						errors++;
					end
					if (normal_z !== e.nz) begin
						$error("normal_z expected %0d actual %0d", e.nz, normal_z);
						errors++;
					end
					if (degenerate !== e.deg) begin
						$error("degenerate expected %0d actual %0d", e.deg, degenerate);
						errors++;
					end
				end
			end
			idle_cycles = item_taken ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("triangle_face_normal verification failed");
				$finish;
			end else begin
				if (quiet) begin
					nrm_stall <= 1'b0;
				end else if (stall_left > 0) begin
					stall_left--;
					nrm_stall <= stall_left > 0;
				end else if (free_left > 0) begin
					free_left--;
					nrm_stall <= 1'b0;
				end else if ($urandom_range(0, 2) == 0) begin
					stall_left = $urandom_range(1, 11);
					nrm_stall <= 1'b1;
				end else begin
					free_left = $urandom_range(1, 30);
					nrm_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		vtx_valid <= 1'b0;
		for (int i = 0; i < 9; i++)
			coord[i] <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_full(450);
		test_random_scaled(400);
		test_degenerate(100);
		test_back_to_back(250);
		vtx_valid <= 1'b0;
		while (expected_normals.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && expected_normals.size() == 0)
			$display("triangle_face_normal verification clean");
		else
			$display("triangle_face_normal verification failed");
		$finish;
	end
endmodule
